FILE: src/hasp_pkg.sv
// Shared types and constants for the hex-ascii sensor packet parser.
// Used by hasp_cfg_regs, hasp_parser and the top level; no dependencies.

package hasp_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_PACKET_TYPE = 2'd0;
    localparam logic [1:0] CFG_TEMP_CODE   = 2'd1;
    localparam logic [1:0] CFG_HUMID_CODE  = 2'd2;
    localparam logic [1:0] CFG_DIST_CODE   = 2'd3;

    // configuration reset values
    localparam logic [7:0] PACKET_TYPE_RESET = 8'h12;
    localparam logic [7:0] TEMP_CODE_RESET   = 8'h10;
    localparam logic [7:0] HUMID_CODE_RESET  = 8'h11;
    localparam logic [7:0] DIST_CODE_RESET   = 8'h30;

    // sensor kind codes
    localparam logic [1:0] KIND_TEMP  = 2'd0;
    localparam logic [1:0] KIND_HUMID = 2'd1;
    localparam logic [1:0] KIND_DIST  = 2'd2;

    // current configuration values
    typedef struct packed {
        logic [7:0] packet_type_match;
        logic [7:0] temperature_code;
        logic [7:0] humidity_code;
        logic [7:0] distance_code;
    } hasp_cfg_t;

    // one decoded result from the parser
    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
        logic [9:0] node;
        logic [9:0] sensor;
        logic [9:0] payload;
    } hasp_result_t;

endpackage

FILE: src/hex_ascii_sensor_packet_parser_unit.sv
// Top level of the hex-ascii sensor packet parser.
// Depends on hasp_pkg, hasp_cfg_regs and hasp_parser.

// Takes one received byte per request and parses packets of the form
// T<hh>N<hh>I<hh>P<hh>, producing a sensor result after the last payload
// digit when the type matches, the payload tag is 'P' and the sensor id
// matches a configured code. A byte can be accepted every cycle while
// in_stall is low: it lands in an input register, is decoded by the phase
// machine and any result goes to the output register as the byte advances.
// in_stall rises only when the input register holds a byte and the output
// register holds a result that out_stall is holding back. Configuration is
// written through cfg_write / cfg_index / cfg_data; the user must write it
// only while the block is idle, as the block itself does not enforce this.

module hex_ascii_sensor_packet_parser_unit
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] sensor_kind,
    output logic [9:0] node_number,
    output logic [9:0] sensor_number,
    output logic [9:0] payload_value
);

    hasp_pkg::hasp_cfg_t    cfg;
    hasp_pkg::hasp_result_t result;

    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       step;
    logic       out_valid_reg;
    logic [1:0] kind_reg;
    logic [9:0] node_reg;
    logic [9:0] sensor_reg;
    logic [9:0] payload_reg;

    hasp_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // the held byte advances when the output register can take a result
    assign step     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !step;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

    hasp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (byte_reg),
        .cfg     (cfg),
        .result  (result)
    );

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (step)
        begin
            out_valid_reg <= result.hit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (step && result.hit)
        begin
            kind_reg    <= result.kind;
            node_reg    <= result.node;
            sensor_reg  <= result.sensor;
            payload_reg <= result.payload;
        end
    end

    assign out_valid     = out_valid_reg;
    assign sensor_kind   = kind_reg;
    assign node_number   = node_reg;
    assign sensor_number = sensor_reg;
    assign payload_value = payload_reg;

endmodule

FILE: src/hasp_cfg_regs.sv
// Configuration register bank of the sensor packet parser.
// Depends on hasp_pkg for register indexes, reset values and the config struct.

module hasp_cfg_regs
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [7:0]        cfg_data,
    output hasp_pkg::hasp_cfg_t cfg
);

    hasp_pkg::hasp_cfg_t cfg_reg;

    // register writes by index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.packet_type_match <= hasp_pkg::PACKET_TYPE_RESET;
            cfg_reg.temperature_code  <= hasp_pkg::TEMP_CODE_RESET;
            cfg_reg.humidity_code     <= hasp_pkg::HUMID_CODE_RESET;
            cfg_reg.distance_code     <= hasp_pkg::DIST_CODE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                hasp_pkg::CFG_PACKET_TYPE: cfg_reg.packet_type_match <= cfg_data;
                hasp_pkg::CFG_TEMP_CODE:   cfg_reg.temperature_code  <= cfg_data;
                hasp_pkg::CFG_HUMID_CODE:  cfg_reg.humidity_code     <= cfg_data;
                hasp_pkg::CFG_DIST_CODE:   cfg_reg.distance_code     <= cfg_data;
                default:                   cfg_reg.distance_code     <= cfg_reg.distance_code;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: src/hasp_parser.sv
// Packet phase machine: decodes hex digit pairs and tracks node and sensor IDs.
// Depends on hasp_pkg for the config and result structs and kind codes.

module hasp_parser
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [7:0]             rx_byte,
    input  hasp_pkg::hasp_cfg_t    cfg,
    output hasp_pkg::hasp_result_t result
);

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_TYPE_HI = 4'd1,
        PH_TYPE_LO = 4'd2,
        PH_N_TAG   = 4'd3,
        PH_N_HI    = 4'd4,
        PH_N_LO    = 4'd5,
        PH_I_TAG   = 4'd6,
        PH_I_HI    = 4'd7,
        PH_I_LO    = 4'd8,
        PH_P_TAG   = 4'd9,
        PH_PAY_HI  = 4'd10,
        PH_PAY_LO  = 4'd11
    } phase_t;

    localparam logic [5:0] BAD_DIGIT = 6'd42;
    localparam logic [7:0] CASE_BIT  = 8'h20;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_A_LC = 8'h61;
    localparam logic [7:0] CHAR_T    = 8'h54;
    localparam logic [7:0] CHAR_N    = 8'h4E;
    localparam logic [7:0] CHAR_I    = 8'h49;
    localparam logic [7:0] CHAR_P    = 8'h50;

    phase_t     phase_reg, phase_next;
    logic [5:0] high_digit_reg, high_digit_next;
    logic [9:0] node_reg, node_next;
    logic [9:0] sensor_reg, sensor_next;
    logic       tag_p_reg, tag_p_next;

    logic [7:0] folded;
    logic [7:0] digit_wide;
    logic [5:0] digit;
    logic [9:0] pair;
    logic       is_temp, is_humid, is_dist;

    // hex digit decode, either case, bad digits map to 42
    always_comb
    begin
        folded     = rx_byte | CASE_BIT;
        digit_wide = 8'd0;
        digit      = BAD_DIGIT;
        if (rx_byte inside {[8'h30:8'h39]})
        begin
            digit_wide = rx_byte - CHAR_ZERO;
            digit      = digit_wide[5:0];
        end
        else if (folded inside {[8'h61:8'h66]})
        begin
            digit_wide = folded - CHAR_A_LC + 8'd10;
            digit      = digit_wide[5:0];
        end
    end

    // two-digit value: high digit times 16 plus low digit
    assign pair = {high_digit_reg, 4'b0000} + {4'b0000, digit};

    // sensor id match, full 10-bit compare
    assign is_temp  = (sensor_reg == {2'b00, cfg.temperature_code});
    assign is_humid = (sensor_reg == {2'b00, cfg.humidity_code});
    assign is_dist  = (sensor_reg == {2'b00, cfg.distance_code});

    // next phase and data
    always_comb
    begin
        phase_next      = phase_reg;
        high_digit_next = high_digit_reg;
        node_next       = node_reg;
        sensor_next     = sensor_reg;
        tag_p_next      = tag_p_reg;
        case (phase_reg)
            PH_TYPE_HI, PH_N_HI, PH_I_HI, PH_PAY_HI:
            begin
                high_digit_next = digit;
                phase_next      = phase_t'(phase_reg + 4'd1);
            end
            PH_TYPE_LO:
                phase_next = (pair == {2'b00, cfg.packet_type_match}) ? PH_N_TAG : PH_IDLE;
            PH_N_TAG:
                phase_next = (rx_byte == CHAR_N) ? PH_N_HI : PH_I_TAG;
            PH_N_LO:
            begin
                node_next  = pair;
                phase_next = PH_I_TAG;
            end
            PH_I_TAG:
                phase_next = (rx_byte == CHAR_I) ? PH_I_HI : PH_P_TAG;
            PH_I_LO:
            begin
                sensor_next = pair;
                phase_next  = PH_P_TAG;
            end
            PH_P_TAG:
            begin
                tag_p_next = (rx_byte == CHAR_P);
                phase_next = PH_PAY_HI;
            end
            PH_PAY_LO:
                phase_next = PH_IDLE;
            default:
                phase_next = (rx_byte == CHAR_T) ? PH_TYPE_HI : PH_IDLE;
        endcase
    end

    // result for the current byte, temperature has priority
    always_comb
    begin
        result.hit     = (phase_reg == PH_PAY_LO) && tag_p_reg && (is_temp || is_humid || is_dist);
        result.kind    = is_temp ? hasp_pkg::KIND_TEMP
                       : (is_humid ? hasp_pkg::KIND_HUMID : hasp_pkg::KIND_DIST);
        result.node    = node_reg;
        result.sensor  = sensor_reg;
        result.payload = pair;
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            high_digit_reg <= 6'd0;
            node_reg       <= 10'd0;
            sensor_reg     <= 10'd0;
            tag_p_reg      <= 1'b0;
        end
        else if (step)
        begin
            phase_reg      <= phase_next;
            high_digit_reg <= high_digit_next;
            node_reg       <= node_next;
            sensor_reg     <= sensor_next;
            tag_p_reg      <= tag_p_next;
        end
    end

endmodule

FILE: tb/sv/tb_hex_ascii_sensor_packet_parser_unit.sv
// Self-checking testbench for hex_ascii_sensor_packet_parser_unit.
// Directed byte table, then random packets checked against an in-bench parser.
// Depends on hasp_pkg and the RTL under src.

module tb_hex_ascii_sensor_packet_parser_unit;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         QUIET_LIMIT = 1000;
    localparam logic [5:0] BAD_DIGIT   = 6'd42;
    localparam logic [7:0] TAG_T       = "T";
    localparam logic [7:0] TAG_N       = "N";
    localparam logic [7:0] TAG_I       = "I";
    localparam logic [7:0] TAG_P       = "P";

    typedef enum logic [3:0] {
        SCAN_IDLE, SCAN_TYPE_HI, SCAN_TYPE_LO, SCAN_N_TAG, SCAN_N_HI, SCAN_N_LO,
        SCAN_I_TAG, SCAN_I_HI, SCAN_I_LO, SCAN_P_TAG, SCAN_PAY_HI, SCAN_PAY_LO
    } scan_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [9:0] node;
        logic [9:0] sensor;
        logic [9:0] payload;
    } sensor_reading_t;

    typedef struct packed {
        logic [7:0]      rx;
        logic            typed;
        sensor_reading_t want;
    } stim_row_t;

    localparam sensor_reading_t NO_READING = '0;

    // noise in idle, a full packet, then one missing N with bad payload digits
    localparam stim_row_t DIRECTED_ROWS [25] = '{
        '{8'h00, 1'b0, NO_READING},
        '{8'hFF, 1'b0, NO_READING},
        '{"t",   1'b0, NO_READING},
        '{"T",   1'b0, NO_READING},
        '{"1",   1'b0, NO_READING},
        '{"2",   1'b0, NO_READING},
        '{"N",   1'b0, NO_READING},
        '{"3",   1'b0, NO_READING},
        '{"f",   1'b0, NO_READING},
        '{"I",   1'b0, NO_READING},
        '{"1",   1'b0, NO_READING},
        '{"0",   1'b0, NO_READING},
        '{"P",   1'b0, NO_READING},
        '{"F",   1'b0, NO_READING},
        '{"f",   1'b1, '{hasp_pkg::KIND_TEMP, 10'h03F, 10'h010, 10'h0FF}},
        '{"T",   1'b0, NO_READING},
        '{"1",   1'b0, NO_READING},
        '{"2",   1'b0, NO_READING},
        '{"x",   1'b0, NO_READING},
        '{"I",   1'b0, NO_READING},
        '{"3",   1'b0, NO_READING},
        '{"0",   1'b0, NO_READING},
        '{"P",   1'b0, NO_READING},
        '{"z",   1'b0, NO_READING},
        '{"z",   1'b1, '{hasp_pkg::KIND_DIST, 10'h03F, 10'h030, 10'd714}}
    };

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_write = 1'b0;
    logic [1:0] cfg_index = hasp_pkg::CFG_PACKET_TYPE;
    logic [7:0] cfg_data  = 8'h00;
    logic       in_valid  = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte   = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [1:0] sensor_kind;
    logic [9:0] node_number;
    logic [9:0] sensor_number;
    logic [9:0] payload_value;

    // parser shadow state and register copies
    scan_phase_t scan      = SCAN_IDLE;
    logic [5:0]  hi_nib    = '0;
    logic [9:0]  node_q    = '0;
    logic [9:0]  sensor_q  = '0;
    logic        saw_p     = 1'b0;
    logic [7:0]  cfg_type  = hasp_pkg::PACKET_TYPE_RESET;
    logic [7:0]  cfg_temp  = hasp_pkg::TEMP_CODE_RESET;
    logic [7:0]  cfg_humid = hasp_pkg::HUMID_CODE_RESET;
    logic [7:0]  cfg_dist  = hasp_pkg::DIST_CODE_RESET;

    sensor_reading_t pending_readings[$];

    int bytes_sent    = 0;
    int readings_seen = 0;
    int errors        = 0;
    int quiet_cycles  = 0;
    int pkt_left      = 0;
    bit steady        = 1'b0;
    bit hold_req      = 1'b0;

    hex_ascii_sensor_packet_parser_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .rx_byte       (rx_byte),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .sensor_kind   (sensor_kind),
        .node_number   (node_number),
        .sensor_number (sensor_number),
        .payload_value (payload_value)
    );

    always #5 clk = ~clk;

    // hex digit value, either case, 42 for anything else
    function automatic logic [5:0] hex_nibble(input logic [7:0] b);
        logic [7:0] folded;
        folded = b | 8'h20;
        if (b >= "0" && b <= "9")
            return 6'(b - "0");
        if (folded >= "a" && folded <= "f")
            return 6'(folded - "a" + 8'd10);
        return BAD_DIGIT;
    endfunction

    // advance the shadow parser by one byte, report a reading if one completes
    function automatic void parse_step(input logic [7:0] b, output logic hit,
                                       output sensor_reading_t r);
        logic [9:0] pair;
        pair = {hi_nib, 4'b0000} + 10'(hex_nibble(b));
        hit  = 1'b0;
        r    = NO_READING;
        case (scan)
            SCAN_TYPE_HI:
            begin
                hi_nib = hex_nibble(b);
                scan   = SCAN_TYPE_LO;
            end
            SCAN_N_HI:
            begin
                hi_nib = hex_nibble(b);
                scan   = SCAN_N_LO;
            end
            SCAN_I_HI:
            begin
                hi_nib = hex_nibble(b);
                scan   = SCAN_I_LO;
            end
            SCAN_PAY_HI:
            begin
                hi_nib = hex_nibble(b);
                scan   = SCAN_PAY_LO;
            end
            SCAN_TYPE_LO: scan = (pair == {2'b00, cfg_type}) ? SCAN_N_TAG : SCAN_IDLE;
            SCAN_N_TAG:   scan = (b == TAG_N) ? SCAN_N_HI : SCAN_I_TAG;
            SCAN_N_LO:
            begin
                node_q = pair;
                scan   = SCAN_I_TAG;
            end
            SCAN_I_TAG:   scan = (b == TAG_I) ? SCAN_I_HI : SCAN_P_TAG;
            SCAN_I_LO:
            begin
                sensor_q = pair;
                scan     = SCAN_P_TAG;
            end
            SCAN_P_TAG:
            begin
                saw_p = (b == TAG_P);
                scan  = SCAN_PAY_HI;
            end
            SCAN_PAY_LO:
            begin
                scan = SCAN_IDLE;
                if (saw_p)
                begin
                    hit = 1'b1;
                    if (sensor_q == {2'b00, cfg_temp})
                        r.kind = hasp_pkg::KIND_TEMP;
                    else if (sensor_q == {2'b00, cfg_humid})
                        r.kind = hasp_pkg::KIND_HUMID;
                    else if (sensor_q == {2'b00, cfg_dist})
                        r.kind = hasp_pkg::KIND_DIST;
                    else
                        hit = 1'b0;
                    r.node    = node_q;
                    r.sensor  = sensor_q;
                    r.payload = pair;
                end
            end
            default: scan = (b == TAG_T) ? SCAN_TYPE_HI : SCAN_IDLE;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10)
            return 8'("0" + v);
        return 8'((($urandom_range(1) == 0) ? "A" : "a") + v - 8'd10);
    endfunction

    // a byte that is not a hex digit, often a stray T
    function automatic logic [7:0] junk_digit();
        logic [7:0] b;
        if ($urandom_range(3) == 0)
            return TAG_T;
        b = 8'($urandom);
        while (hex_nibble(b) != BAD_DIGIT)
            b = 8'($urandom);
        return b;
    endfunction

    // hand one byte over, with random idle cycles ahead of the request
    task automatic push_byte(input logic [7:0] b);
        while (!steady && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic offer_byte(input logic [7:0] b);
        logic            hit;
        sensor_reading_t r;
        push_byte(b);
        parse_step(b, hit, r);
        if (hit)
            pending_readings.push_back(r);
        bytes_sent++;
    endtask

    // byte of a packet under construction, dropped once the packet is cut short
    task automatic put(input logic [7:0] b);
        if (pkt_left != 0)
        begin
            offer_byte(b);
            pkt_left--;
        end
    endtask

    task automatic send_pair(input logic [7:0] v, input int bad_pct);
        put(($urandom_range(99) < bad_pct) ? junk_digit() : hex_char(v[7:4]));
        put(($urandom_range(99) < bad_pct) ? junk_digit() : hex_char(v[3:0]));
    endtask

    // mostly well-formed packets, some truncated or with missing sections
    task automatic send_packet();
        logic [7:0] sensor_id;
        pkt_left = ($urandom_range(9) == 0) ? $urandom_range(1, 10) : 16;
        case ($urandom_range(3))
            0:       sensor_id = cfg_temp;
            1:       sensor_id = cfg_humid;
            2:       sensor_id = cfg_dist;
            default: sensor_id = 8'($urandom);
        endcase
        put(TAG_T);
        send_pair(($urandom_range(99) < 85) ? cfg_type : 8'($urandom), 3);
        if ($urandom_range(99) < 80)
        begin
            put(TAG_N);
            send_pair(8'($urandom), 5);
        end
        else
            put(8'($urandom));
        if ($urandom_range(99) < 80)
        begin
            put(TAG_I);
            send_pair(sensor_id, 5);
        end
        else
            put(8'($urandom));
        put(($urandom_range(99) < 85) ? TAG_P : 8'($urandom));
        send_pair(8'($urandom), 5);
    endtask

    task automatic run_random(input int n);
        int stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at)
        begin
            if ($urandom_range(99) < 20)
                repeat ($urandom_range(1, 3)) offer_byte(8'($urandom));
            send_packet();
        end
    endtask

    // stop sending and wait for every outstanding reading
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_readings.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        case (idx)
            hasp_pkg::CFG_PACKET_TYPE: cfg_type  = v;
            hasp_pkg::CFG_TEMP_CODE:   cfg_temp  = v;
            hasp_pkg::CFG_HUMID_CODE:  cfg_humid = v;
            default:                   cfg_dist  = v;
        endcase
        @(posedge clk);
    endtask

    // registers change only once the parser has gone quiet
    task automatic load_config(input logic [7:0] t, input logic [7:0] te,
                               input logic [7:0] h, input logic [7:0] d);
        drain();
        repeat (4) @(posedge clk);
        write_reg(hasp_pkg::CFG_PACKET_TYPE, t);
        write_reg(hasp_pkg::CFG_TEMP_CODE, te);
        write_reg(hasp_pkg::CFG_HUMID_CODE, h);
        write_reg(hasp_pkg::CFG_DIST_CODE, d);
        cfg_write <= 1'b0;
    endtask

    // output side: random stalls, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (80) @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
            end
            else
                out_stall <= !steady && ($urandom_range(99) < 30);
        end
    end

    // compare each accepted reading, then watchdog on accepted traffic
    always @(posedge clk)
    begin
        sensor_reading_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            readings_seen++;
            if (pending_readings.size() == 0)
            begin
                $error("unexpected reading: kind %0d node %0d sensor %0d payload %0d",
                       sensor_kind, node_number, sensor_number, payload_value);
                errors++;
            end
            else
            begin
                exp_r = pending_readings.pop_front();
                if (sensor_kind !== exp_r.kind)
                begin
                    $error("sensor_kind: expected %0d, got %0d", exp_r.kind, sensor_kind);
                    errors++;
                end
                if (node_number !== exp_r.node)
                begin
                    $error("node_number: expected %0d, got %0d", exp_r.node, node_number);
                    errors++;
                end
                if (sensor_number !== exp_r.sensor)
                begin
                    $error("sensor_number: expected %0d, got %0d",
                           exp_r.sensor, sensor_number);
                    errors++;
                end
                if (payload_value !== exp_r.payload)
                begin
                    $error("payload_value: expected %0d, got %0d",
                           exp_r.payload, payload_value);
                    errors++;
                end
            end
        end
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        logic            hit;
        sensor_reading_t r;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows, typed expectations where given
        foreach (DIRECTED_ROWS[i])
        begin
            push_byte(DIRECTED_ROWS[i].rx);
            parse_step(DIRECTED_ROWS[i].rx, hit, r);
            if (DIRECTED_ROWS[i].typed)
                pending_readings.push_back(DIRECTED_ROWS[i].want);
            else if (hit)
                pending_readings.push_back(r);
            bytes_sent++;
        end

        run_random(100);

        // extremes, with a long output hold-off
        load_config(8'h00, 8'hFF, 8'h00, 8'h7F);
        hold_req = 1'b1;
        run_random(100);

        // all codes equal, no idling anywhere
        load_config(8'hFF, 8'h5A, 8'h5A, 8'h5A);
        steady = 1'b1;
        run_random(100);
        steady = 1'b0;

        // temperature and distance share a code, sender pauses midway
        load_config(8'hA5, 8'h20, 8'h21, 8'h20);
        run_random(50);
        drain();
        run_random(50);

        // humidity and distance share a code
        load_config(8'h3C, 8'hC3, 8'h01, 8'h01);
        run_random(100);

        load_config(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(100);

        load_config(hasp_pkg::PACKET_TYPE_RESET, hasp_pkg::TEMP_CODE_RESET,
                    hasp_pkg::HUMID_CODE_RESET, hasp_pkg::DIST_CODE_RESET);
        run_random(100);

        drain();
        repeat (10) @(posedge clk);

        $display("covered %0d bytes and %0d sensor readings over seven register settings",
                 bytes_sent, readings_seen);
        $display("with an output hold-off, a full drain pause and an idle-free stretch");
        if (errors == 0 && pending_readings.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
